// ===== src/mslcg_pkg.sv =====
`timescale 1ns / 1ps

package mslcg_pkg;

    localparam int STATE_W = 31;
    localparam int BOUND_W = 32;
    localparam int PROD_W  = 46;
    localparam int MULT_W  = 15;
    localparam int CNT_W   = 5;

    localparam logic [MULT_W-1:0]  LCG_MULT  = 15'd16807;
    localparam logic [STATE_W-1:0] LCG_MOD   = 31'h7fffffff;
    localparam logic [STATE_W-1:0] SEED_MASK = 31'd123459876;

    // one restoring step per dividend bit
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(STATE_W - 1);

    localparam logic CMD_DRAW   = 1'b0;
    localparam logic CMD_RESEED = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_FOLD,
        ST_REDUCE,
        ST_DIV,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic load_seed;
        logic capture_bound;
        logic clear_rem;
        logic mul;
        logic fold;
        logic reduce;
        logic div_step;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_reseed;
        logic bound_pos;
        logic div_last;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== src/mslcg_ctrl.sv =====
`timescale 1ns / 1ps

module mslcg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  mslcg_pkg::dp_stat_t  stat,
    output mslcg_pkg::dp_cmd_t   cmd
);

    mslcg_pkg::ctrl_state_t state_reg;
    mslcg_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mslcg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mslcg_pkg::ST_IDLE: begin
                if (s_tvalid && !stat.is_reseed) begin
                    state_next = stat.bound_pos ? mslcg_pkg::ST_MUL : mslcg_pkg::ST_OUT;
                end
            end
            mslcg_pkg::ST_MUL:    state_next = mslcg_pkg::ST_FOLD;
            mslcg_pkg::ST_FOLD:   state_next = mslcg_pkg::ST_REDUCE;
            mslcg_pkg::ST_REDUCE: state_next = mslcg_pkg::ST_DIV;
            mslcg_pkg::ST_DIV: begin
                if (stat.div_last) begin
                    state_next = mslcg_pkg::ST_OUT;
                end
            end
            mslcg_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = mslcg_pkg::ST_IDLE;
                end
            end
            default: state_next = mslcg_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            mslcg_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (stat.is_reseed) begin
                        cmd.load_seed = 1'b1;
                    end else if (stat.bound_pos) begin
                        cmd.capture_bound = 1'b1;
                    end else begin
                        cmd.clear_rem = 1'b1;
                    end
                end
            end
            mslcg_pkg::ST_MUL:    cmd.mul      = 1'b1;
            mslcg_pkg::ST_FOLD:   cmd.fold     = 1'b1;
            mslcg_pkg::ST_REDUCE: cmd.reduce   = 1'b1;
            mslcg_pkg::ST_DIV:    cmd.div_step = 1'b1;
            mslcg_pkg::ST_OUT:    cmd.load_out = stat.out_free;
            default: ;
        endcase
    end

endmodule

// ===== src/mslcg_dp.sv =====
`timescale 1ns / 1ps

module mslcg_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [63:0]          s_tdata,
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,
    input  mslcg_pkg::dp_cmd_t   cmd,
    output mslcg_pkg::dp_stat_t  stat
);

    localparam int SW = mslcg_pkg::STATE_W;

    logic [SW-1:0]                    gen_state_reg;
    logic [SW-1:0]                    bound_reg;
    logic [mslcg_pkg::PROD_W-1:0]     prod_reg;
    logic [SW:0]                      fold_reg;
    logic [SW-1:0]                    quo_reg;
    logic [SW-1:0]                    rem_reg;
    logic [mslcg_pkg::CNT_W-1:0]      cnt_reg;
    logic                             m_tvalid_reg;
    logic [31:0]                      m_tdata_reg;

    logic [SW-1:0] seed_in;
    logic [SW-1:0] seed_eff;
    logic [SW:0]   reduced;
    logic [SW:0]   rem_trial;
    logic [SW:0]   rem_diff;
    logic          rem_ge;

    assign seed_in  = s_tdata[62:32];
    assign seed_eff = (seed_in == mslcg_pkg::SEED_MASK) ? '0 : seed_in;

    // Mersenne modulus: 2^31 == 1, so fold high bits onto low bits, then one subtract
    assign reduced = (fold_reg >= {1'b0, mslcg_pkg::LCG_MOD})
                   ? fold_reg - {1'b0, mslcg_pkg::LCG_MOD} : fold_reg;

    assign rem_trial = {rem_reg, quo_reg[SW-1]};
    assign rem_diff  = rem_trial - {1'b0, bound_reg};
    assign rem_ge    = rem_trial >= {1'b0, bound_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_state_reg <= mslcg_pkg::SEED_MASK;
            cnt_reg       <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.load_seed) begin
                gen_state_reg <= seed_eff ^ mslcg_pkg::SEED_MASK;
            end else if (cmd.reduce) begin
                gen_state_reg <= reduced[SW-1:0];
            end
            if (cmd.reduce) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + mslcg_pkg::CNT_W'(1);
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture_bound) begin
            bound_reg <= s_tdata[SW-1:0];
        end
        if (cmd.mul) begin
            prod_reg <= mslcg_pkg::PROD_W'(gen_state_reg)
                      * mslcg_pkg::PROD_W'(mslcg_pkg::LCG_MULT);
        end
        if (cmd.fold) begin
            fold_reg <= {1'b0, prod_reg[SW-1:0]}
                      + (SW+1)'(prod_reg[mslcg_pkg::PROD_W-1:SW]);
        end
        if (cmd.reduce) begin
            quo_reg <= reduced[SW-1:0];
        end else if (cmd.div_step) begin
            quo_reg <= {quo_reg[SW-2:0], 1'b0};
        end
        if (cmd.reduce || cmd.clear_rem) begin
            rem_reg <= '0;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? rem_diff[SW-1:0] : rem_trial[SW-1:0];
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {1'b0, rem_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign stat.is_reseed = (s_tuser == mslcg_pkg::CMD_RESEED);
    assign stat.bound_pos = !s_tdata[mslcg_pkg::BOUND_W-1] && (s_tdata[SW-1:0] != '0);
    assign stat.div_last  = (cnt_reg == mslcg_pkg::DIV_LAST);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

endmodule

// ===== src/minimal_standard_lcg_ranged.sv =====
`timescale 1ns / 1ps
// Minimal standard generator (16807 * x mod 2^31-1) with bounded draws.
// Input stream: s_tuser selects the command (0 draw, 1 reseed); s_tdata
// carries the draw bound and the reseed value. One command is taken at a
// time; s_tready is high only while the sequencer is idle.
// Reseed: state loads in the accepting cycle, no result, next transfer can
// follow in the next cycle.
// Draw with bound <= 0: the remainder is cleared at the transfer and 0 is
// registered in the output phase, state untouched; the sequencer then
// returns to idle for the next command.
// Draw with positive bound: a multiply, a fold and a reduce step for the
// Mersenne modulus, then a restoring remainder unit that retires one dividend
// bit per cycle; the remainder is registered in the output phase as well.
// The result sits in an output register; if the receiver holds m_tready low,
// the sequencer waits with the finished remainder until the register frees.
// Reset (aresetn low, synchronous) sets the state to 123459876, drops m_tvalid
// and returns the sequencer to idle.

module minimal_standard_lcg_ranged (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] bound, [62:32] seed_value, [63] zero
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [30:0] value, [31] zero
);

    mslcg_pkg::dp_cmd_t  cmd;
    mslcg_pkg::dp_stat_t stat;

    // sequencer: steps multiply, fold, reduce and divide phases
    mslcg_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // generator state, modular multiply, remainder unit, output register
    mslcg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

    // a positive-bound draw occupies the sequencer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && !s_tdata[31] && (s_tdata[30:0] != 31'd0))
        |=> !s_tready)
    else $error("input taken during a draw in progress");

    // reseed finishes in the accepting cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> s_tready)
    else $error("reseed did not return to idle");

    // results are loaded only from the busy output phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result appeared while sequencer idle");

    // a nonpositive-bound draw with the output register empty yields a result after the output phase
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && !s_tuser && (s_tdata[31] || (s_tdata[30:0] == 31'd0))
         && !m_tvalid) |=> ##1 m_tvalid)
    else $error("zero result missing");

endmodule

// ===== dv/tb_minimal_standard_lcg_ranged.sv =====
`timescale 1ns / 1ps

module tb_minimal_standard_lcg_ranged;

    // Schrage split of the modulus: 2^31-1 = 16807 * 127773 + 2836
    localparam longint PM_MULT = 16807;
    localparam longint PM_MOD  = 2147483647;
    localparam longint PM_QUOT = 127773;
    localparam longint PM_REM  = 2836;

    localparam int RANDOM_ITEMS = 780;
    localparam int LONG_HOLD    = 300;   // receiver stall used for the backpressure test
    localparam int DRAIN_CYCLES = 48;    // wait after the last owed value, longer than a whole draw

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // [31:0] bound, [62:32] seed_value, [63] zero
    logic        s_tuser  = 1'b0;   // [0] command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [30:0] value, [31] zero

    // predictor state and the values still owed by the block
    logic [mslcg_pkg::STATE_W-1:0] gen_state;
    logic [mslcg_pkg::STATE_W-1:0] expected_values[$];
    int                            mismatch_count = 0;

    // idling controls, changed by the test tasks
    bit tx_idle     = 1'b1;
    bit rx_idle     = 1'b1;
    int rx_hold_req = 0;

    minimal_standard_lcg_ranged dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // 16807 * x mod (2^31-1) without overflow. An all-ones state folds to 0,
    // and 0 is a fixed point, so a generator landing there stays stuck.
    function automatic logic [mslcg_pkg::STATE_W-1:0] schrage_next(
        input logic [mslcg_pkg::STATE_W-1:0] x);
        longint cur, hi, lo, nxt;
        cur = longint'(x);
        hi  = cur / PM_QUOT;
        lo  = cur - hi * PM_QUOT;
        nxt = PM_MULT * lo - PM_REM * hi;
        if (nxt < 0)
            nxt += PM_MOD;
        return nxt[mslcg_pkg::STATE_W-1:0];
    endfunction

    // Applies one accepted command to the predicted state and queues the
    // value a draw must return.
    function automatic void predict_transfer(input logic cmd,
                                             input logic [mslcg_pkg::BOUND_W-1:0] bound,
                                             input logic [mslcg_pkg::STATE_W-1:0] seed);
        logic [mslcg_pkg::STATE_W-1:0] s;
        logic [mslcg_pkg::BOUND_W-1:0] wide;
        if (cmd == mslcg_pkg::CMD_RESEED) begin
            // the mask itself would cancel to zero, so it maps to seed 0
            s = (seed == mslcg_pkg::SEED_MASK) ? '0 : seed;
            gen_state = s ^ mslcg_pkg::SEED_MASK;
        end else if ($signed(bound) <= 0) begin
            // nonpositive bound: answer 0, generator untouched
            expected_values.push_back('0);
        end else begin
            gen_state = schrage_next(gen_state);
            wide = {1'b0, gen_state} % bound;
            expected_values.push_back(wide[mslcg_pkg::STATE_W-1:0]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one command per call. Returns at the edge of the transfer.
    // ------------------------------------------------------------------
    task automatic push_command(input logic cmd, input logic [mslcg_pkg::BOUND_W-1:0] bound,
                                input logic [mslcg_pkg::STATE_W-1:0] seed);
        int gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, seed, bound};
        do
            @(posedge aclk);
        while (!s_tready);
        predict_transfer(cmd, bound, seed);
    endtask

    task automatic draw(input logic [mslcg_pkg::BOUND_W-1:0] bound);
        push_command(mslcg_pkg::CMD_DRAW, bound, mslcg_pkg::STATE_W'($urandom));
    endtask

    task automatic reseed(input logic [mslcg_pkg::STATE_W-1:0] seed);
        push_command(mslcg_pkg::CMD_RESEED, $urandom, seed);
    endtask

    // Drops the offer, waits for every owed value, then lets a reseed that
    // may still be in flight settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_values.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall before each transfer; a posted long hold
    // keeps m_tready low long enough that the block backs up its input.
    // ------------------------------------------------------------------
    initial begin
        int hold;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hold = rx_idle ? $urandom_range(0, 14) : 0;
            if (rx_hold_req != 0) begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do
                @(posedge aclk);
            while (!m_tvalid);
        end
    end

    // Result checker: every transfer is matched against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_values.size() == 0) begin
                $error("value: transfer with nothing expected, actual %0d", m_tdata[30:0]);
                mismatch_count++;
            end else if (m_tdata[30:0] !== expected_values[0]) begin
                $error("value mismatch: expected %0d, actual %0d",
                       expected_values[0], m_tdata[30:0]);
                mismatch_count++;
                void'(expected_values.pop_front());
            end else begin
                void'(expected_values.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First draws straight out of reset expose the reset state.
    task automatic test_reset_state();
        draw(32'h7fffffff);
        draw(32'd1);
        draw(32'h7ffffffe);
        wait_drained();
    endtask

    // Bound extremes, nonpositive bounds included.
    task automatic test_bound_extremes();
        draw(32'd0);
        draw(32'hffffffff);
        draw(32'h80000000);
        draw(32'd1);
        draw(32'd2);
        draw(32'h7fffffff);
        draw(32'h40000000);
        wait_drained();
    endtask

    // Reseed corner cases: zero, the mask itself, all ones, and the one
    // seed that drives the state to all ones and then locks it at zero.
    task automatic test_reseed_cases();
        reseed('0);
        draw(32'h7fffffff);
        reseed(mslcg_pkg::SEED_MASK);
        draw(32'h7fffffff);
        reseed('1);
        reseed(mslcg_pkg::STATE_W'(12345));
        draw(32'd1000);
        reseed(~mslcg_pkg::SEED_MASK);
        draw(32'h7fffffff);
        draw(32'd17);
        draw(32'd0);
        reseed(mslcg_pkg::STATE_W'(42));
        draw(32'h7fffffff);
        wait_drained();
    endtask

    // Back-to-back draws with the receiver parked: output register fills,
    // sequencer stalls, and s_tready must drop until the receiver returns.
    task automatic test_backpressure();
        int i;
        tx_idle     = 1'b0;
        rx_hold_req = LONG_HOLD;
        for (i = 0; i < 6; i++)
            draw(mslcg_pkg::BOUND_W'($urandom_range(1, 1000)));
        reseed(mslcg_pkg::STATE_W'($urandom));
        draw(32'hfffffff0);
        draw(32'd77);
        tx_idle = 1'b1;
        wait_drained();
    endtask

    // Mostly draws over a spread of bound sizes, with reseeds mixed in and
    // idling switched on and off in stretches.
    task automatic test_random_stream(input int n_items);
        int                            i;
        logic [mslcg_pkg::BOUND_W-1:0] b;
        logic [mslcg_pkg::STATE_W-1:0] sd;
        for (i = 0; i < n_items; i++) begin
            if (i % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            b  = $urandom;
            sd = mslcg_pkg::STATE_W'($urandom);
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 7))
                    0:       sd = mslcg_pkg::SEED_MASK;
                    1:       sd = ~mslcg_pkg::SEED_MASK;
                    default: ;
                endcase
                reseed(sd);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1:    b = mslcg_pkg::BOUND_W'($urandom_range(1, 16));
                    2, 3:    b = mslcg_pkg::BOUND_W'($urandom_range(1, 65536));
                    4:       b = 32'h7fffffff - mslcg_pkg::BOUND_W'($urandom_range(0, 3));
                    5:       ;   // full 32-bit range, half of it negative
                    6:       b = -mslcg_pkg::BOUND_W'($urandom_range(0, 4));
                    default: b = {1'b0, b[30:0]} >> $urandom_range(0, 30);
                endcase
                draw(b);
            end
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("tb_minimal_standard_lcg_ranged: FAIL");
        $finish;
    end

    initial begin
        gen_state = mslcg_pkg::SEED_MASK;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (4) @(posedge aclk);

        test_reset_state();
        test_bound_extremes();
        test_reseed_cases();
        test_backpressure();
        test_random_stream(RANDOM_ITEMS);

        wait_drained();
        if (mismatch_count == 0 && expected_values.size() == 0) begin
            $display("tb_minimal_standard_lcg_ranged: PASS");
        end else begin
            $display("tb_minimal_standard_lcg_ranged: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mslcg_pkg.sv
src/mslcg_ctrl.sv
src/mslcg_dp.sv
src/minimal_standard_lcg_ranged.sv
dv/tb_minimal_standard_lcg_ranged.sv
